/* rtl/core/bilinear_image_sampler_macros.svh */
// assertion macros used by the bilinear image sampler top level
`ifndef BILINEAR_IMAGE_SAMPLER_MACROS_SVH
`define BILINEAR_IMAGE_SAMPLER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BIS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear image sampler: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear image sampler: next-cycle check failed");

`endif

/* rtl/core/bis_pkg.sv */
// types, constants and helper functions of the bilinear image sampler
package bis_pkg;

    // image geometry
    localparam int IMAGE_DIM  = 550;
    localparam int CENTRE     = IMAGE_DIM / 2;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = $clog2(IMAGE_DIM + 1);
    localparam int POS_W      = IDX_W + FRAC_W;
    localparam int HALF       = (IMAGE_DIM + 1) / 2;
    localparam int HALF_W     = $clog2(HALF);
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int ADDR_W     = $clog2(BANK_DEPTH);
    localparam int NBANK      = 4;

    // field widths
    localparam int ROW_W   = 10;
    localparam int CMP_W   = ROW_W + 1;
    localparam int PIX_W   = 32;
    localparam int COORD_W = 32;
    localparam int CFG_W   = 32;
    localparam int INT_W   = 40;

    // arithmetic widths and shifts
    localparam int OFF_W       = COORD_W + CFG_W;
    localparam int PROD_FRAC   = 48;
    localparam int POS_SHIFT   = 32;
    localparam int WGT_W       = 2 * FRAC_W + 1;
    localparam int MUL_W       = PIX_W + WGT_W + 1;
    localparam int PROD_W      = 64;
    localparam int SUM_W       = PROD_W + 2;
    localparam int VQ_SHIFT    = 32;
    localparam int VQ_W        = 31;
    localparam int SCALED_W    = VQ_W + CFG_W;
    localparam int SCALE_SHIFT = 24;

    // result queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] PPU_RESET = 32'h0100_0000;
    localparam logic [CFG_W-1:0] IAP_RESET = 32'h0100_0000;

    localparam logic [OFF_W-1:0]  OFF_LIMIT = OFF_W'(CENTRE) << PROD_FRAC;
    localparam logic [POS_W-1:0]  CENTRE_Q  = POS_W'(CENTRE) << FRAC_W;
    localparam logic [FRAC_W:0]   ONE_Q     = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(IMAGE_DIM - 1);
    localparam logic [IDX_W:0]    LAST_IDXX = (IDX_W + 1)'(IMAGE_DIM - 1);
    localparam logic [CMP_W-1:0]  DIM_CMP   = CMP_W'(IMAGE_DIM);

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXELS_PER_UNIT    = 1'd0,
        REG_INVERSE_PIXEL_AREA = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        kind_t                      kind;
        logic [ROW_W-1:0]           pixel_row;
        logic [ROW_W-1:0]           pixel_col;
        logic signed [PIX_W-1:0]    pixel_value;
        logic signed [COORD_W-1:0]  x_coord;
        logic signed [COORD_W-1:0]  z_coord;
    } req_t;

    typedef struct packed {
        logic [INT_W-1:0] intensity;
        logic             in_range;
    } rsp_t;

    // ports of the four parity banks
    typedef struct packed {
        logic [NBANK-1:0]             wr_en;
        logic [ADDR_W-1:0]            wr_addr;
        logic [PIX_W-1:0]             wr_data;
        logic                         rd_en;
        logic [NBANK-1:0][ADDR_W-1:0] rd_addr;
    } mem_port_t;

    // per-sample control travelling beside the bank reads
    // wgt and bank selects indexed by {second row, second column}
    typedef struct packed {
        logic                        in_range;
        logic [1:0]                  rpar;
        logic [1:0]                  cpar;
        logic [NBANK-1:0][WGT_W-1:0] wgt;
    } smp_ctl_t;

    typedef logic [NBANK-1:0][PIX_W-1:0] pix_quad_t;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W:0] i);
        logic [IDX_W-1:0] r;
        if (i > LAST_IDXX)
            r = LAST_IDX;
        else
            r = i[IDX_W-1:0];
        return r;
    endfunction

    // address inside a parity bank from halved row and column
    function automatic logic [ADDR_W-1:0] bank_addr(input logic [HALF_W-1:0] rh,
                                                    input logic [HALF_W-1:0] ch);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(rh) * ADDR_W'(HALF) + ADDR_W'(ch);
        return a;
    endfunction

endpackage

/* rtl/core/bis_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/bis_image.sv */
// image store split into four banks by row and column parity
module bis_image
    import bis_pkg::*;
(
    input  logic      clk,
    input  mem_port_t port,
    output pix_quad_t pix
);

    // bank index is {row parity, column parity}
    for (genvar b = 0; b < NBANK; b++)
    begin : g_bank
        bis_ram #(
            .WIDTH(PIX_W),
            .DEPTH(BANK_DEPTH)
        ) u_bank (
            .clk     (clk),
            .wr_en   (port.wr_en[b]),
            .wr_addr (port.wr_addr),
            .wr_data (port.wr_data),
            .rd_en   (port.rd_en),
            .rd_addr (port.rd_addr[b]),
            .rd_data (pix[b])
        );
    end

endmodule

/* rtl/core/bis_map.sv */
// point mapping, neighbour indices, weights and bank addressing
module bis_map
    import bis_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  req_t             req,
    input  logic [CFG_W-1:0] ppu,
    output mem_port_t        port,
    output logic             smp_valid,
    output smp_ctl_t         smp_ctl
);

    // stage 1: magnitudes
    logic                   s1_valid_reg;
    kind_t                  s1_kind_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic [ROW_W-1:0]       s1_col_reg;
    logic [PIX_W-1:0]       s1_value_reg;
    logic                   s1_xneg_reg;
    logic                   s1_zneg_reg;
    logic [COORD_W-1:0]     s1_xmag_reg;
    logic [COORD_W-1:0]     s1_zmag_reg;
    logic [COORD_W-1:0]     xmag_next;
    logic [COORD_W-1:0]     zmag_next;

    // stage 2: scaled offsets
    logic                   s2_valid_reg;
    kind_t                  s2_kind_reg;
    logic [ROW_W-1:0]       s2_row_reg;
    logic [ROW_W-1:0]       s2_col_reg;
    logic [PIX_W-1:0]       s2_value_reg;
    logic                   s2_xneg_reg;
    logic                   s2_zneg_reg;
    logic [OFF_W-1:0]       s2_px_reg;
    logic [OFF_W-1:0]       s2_pz_reg;

    // stage 3: pixel positions
    logic                   s3_valid_reg;
    kind_t                  s3_kind_reg;
    logic [ROW_W-1:0]       s3_row_reg;
    logic [ROW_W-1:0]       s3_col_reg;
    logic [PIX_W-1:0]       s3_value_reg;
    logic                   s3_inr_reg;
    logic [POS_W-1:0]       s3_cpos_reg;
    logic [POS_W-1:0]       s3_rpos_reg;
    logic                   inr_next;
    logic [POS_W-1:0]       cpos_next;
    logic [POS_W-1:0]       rpos_next;
    logic [POS_W-1:0]       offx;
    logic [POS_W-1:0]       offz;

    // stage 4: bank ports
    logic [NBANK-1:0]             wr_en_reg;
    logic [ADDR_W-1:0]            wr_addr_reg;
    logic [PIX_W-1:0]             wr_data_reg;
    logic                         rd_en_reg;
    logic [NBANK-1:0][ADDR_W-1:0] rd_addr_reg;
    smp_ctl_t                     ctl_reg;
    logic [NBANK-1:0]             wr_en_next;
    logic [ADDR_W-1:0]            wr_addr_next;
    logic                         rd_en_next;
    logic [NBANK-1:0][ADDR_W-1:0] rd_addr_next;
    smp_ctl_t                     ctl_next;

    logic [IDX_W-1:0]  c_int;
    logic [IDX_W-1:0]  r_int;
    logic [FRAC_W-1:0] c_frac;
    logic [FRAC_W-1:0] r_frac;
    logic [IDX_W-1:0]  ca;
    logic [IDX_W-1:0]  cb;
    logic [IDX_W-1:0]  ra;
    logic [IDX_W-1:0]  rb;
    logic [IDX_W-1:0]  c_even;
    logic [IDX_W-1:0]  c_odd;
    logic [IDX_W-1:0]  r_even;
    logic [IDX_W-1:0]  r_odd;
    logic [HALF_W-1:0] ch_even;
    logic [HALF_W-1:0] ch_odd;
    logic [HALF_W-1:0] rh_even;
    logic [HALF_W-1:0] rh_odd;
    logic [FRAC_W:0]   wc1;
    logic [FRAC_W:0]   wc2;
    logic [FRAC_W:0]   wr1;
    logic [FRAC_W:0]   wr2;
    logic              load_ok;
    logic [1:0]        load_bank;

    // ---------------- stage 1 ----------------
    always_comb
    begin
        xmag_next = req.x_coord[COORD_W-1] ? (~req.x_coord + 1'b1) : req.x_coord;
        zmag_next = req.z_coord[COORD_W-1] ? (~req.z_coord + 1'b1) : req.z_coord;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            wr_en_reg    <= '0;
            rd_en_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            wr_en_reg    <= wr_en_next;
            rd_en_reg    <= rd_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_kind_reg  <= req.kind;
            s1_row_reg   <= req.pixel_row;
            s1_col_reg   <= req.pixel_col;
            s1_value_reg <= req.pixel_value;
            s1_xneg_reg  <= req.x_coord[COORD_W-1];
            s1_zneg_reg  <= req.z_coord[COORD_W-1];
            s1_xmag_reg  <= xmag_next;
            s1_zmag_reg  <= zmag_next;
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_value_reg <= s1_value_reg;
            s2_xneg_reg  <= s1_xneg_reg;
            s2_zneg_reg  <= s1_zneg_reg;
            s2_px_reg    <= s1_xmag_reg * ppu;
            s2_pz_reg    <= s1_zmag_reg * ppu;
        end
    end

    // ---------------- stage 3 ----------------
    always_comb
    begin
        inr_next  = (s2_px_reg <= OFF_LIMIT) && (s2_pz_reg <= OFF_LIMIT);
        offx      = s2_px_reg[POS_SHIFT +: POS_W];
        offz      = s2_pz_reg[POS_SHIFT +: POS_W];
        // row counts downward, so z enters with the opposite sign
        cpos_next = s2_xneg_reg ? (CENTRE_Q - offx) : (CENTRE_Q + offx);
        rpos_next = s2_zneg_reg ? (CENTRE_Q + offz) : (CENTRE_Q - offz);
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_row_reg   <= s2_row_reg;
            s3_col_reg   <= s2_col_reg;
            s3_value_reg <= s2_value_reg;
            s3_inr_reg   <= inr_next;
            s3_cpos_reg  <= cpos_next;
            s3_rpos_reg  <= rpos_next;
        end
    end

    // ---------------- stage 4 ----------------
    always_comb
    begin
        c_int  = s3_cpos_reg[POS_W-1:FRAC_W];
        r_int  = s3_rpos_reg[POS_W-1:FRAC_W];
        c_frac = s3_cpos_reg[FRAC_W-1:0];
        r_frac = s3_rpos_reg[FRAC_W-1:0];

        ca = clamp_idx({1'b0, c_int});
        cb = clamp_idx({1'b0, c_int} + 1'b1);
        ra = clamp_idx({1'b0, r_int});
        rb = clamp_idx({1'b0, r_int} + 1'b1);

        // unclamped neighbours differ by one, so each lands in the other parity bank
        c_even = ca[0] ? cb : ca;
        c_odd  = ca[0] ? ca : cb;
        r_even = ra[0] ? rb : ra;
        r_odd  = ra[0] ? ra : rb;

        ch_even = HALF_W'(c_even >> 1);
        ch_odd  = HALF_W'(c_odd >> 1);
        rh_even = HALF_W'(r_even >> 1);
        rh_odd  = HALF_W'(r_odd >> 1);

        rd_addr_next[0] = bank_addr(rh_even, ch_even);
        rd_addr_next[1] = bank_addr(rh_even, ch_odd);
        rd_addr_next[2] = bank_addr(rh_odd,  ch_even);
        rd_addr_next[3] = bank_addr(rh_odd,  ch_odd);

        wc1 = ONE_Q - {1'b0, c_frac};
        wc2 = {1'b0, c_frac};
        wr1 = ONE_Q - {1'b0, r_frac};
        wr2 = {1'b0, r_frac};

        ctl_next.in_range = s3_inr_reg;
        // clamped at the last index: second neighbour reuses the first bank
        ctl_next.rpar[0]  = ra[0];
        ctl_next.rpar[1]  = (ra == rb) ? ra[0] : rb[0];
        ctl_next.cpar[0]  = ca[0];
        ctl_next.cpar[1]  = (ca == cb) ? ca[0] : cb[0];
        ctl_next.wgt[0]   = wr1 * wc1;
        ctl_next.wgt[1]   = wr1 * wc2;
        ctl_next.wgt[2]   = wr2 * wc1;
        ctl_next.wgt[3]   = wr2 * wc2;

        rd_en_next = s3_valid_reg && (s3_kind_reg == KIND_SAMPLE);

        load_ok = s3_valid_reg && (s3_kind_reg == KIND_LOAD)
                  && ({1'b0, s3_row_reg} < DIM_CMP) && ({1'b0, s3_col_reg} < DIM_CMP);
        load_bank    = {s3_row_reg[0], s3_col_reg[0]};
        wr_en_next   = load_ok ? (NBANK'(1) << load_bank) : '0;
        wr_addr_next = bank_addr(HALF_W'(s3_row_reg >> 1), HALF_W'(s3_col_reg >> 1));
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            wr_addr_reg <= wr_addr_next;
            wr_data_reg <= s3_value_reg;
            rd_addr_reg <= rd_addr_next;
            ctl_reg     <= ctl_next;
        end
    end

    assign port.wr_en   = wr_en_reg;
    assign port.wr_addr = wr_addr_reg;
    assign port.wr_data = wr_data_reg;
    assign port.rd_en   = rd_en_reg;
    assign port.rd_addr = rd_addr_reg;
    assign smp_valid    = rd_en_reg;
    assign smp_ctl      = ctl_reg;

endmodule

/* rtl/core/bis_blend.sv */
// bilinear blend of the four bank reads and scaling by inverse pixel area
module bis_blend
    import bis_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             smp_valid,
    input  smp_ctl_t         smp_ctl,
    input  pix_quad_t        pix,
    input  logic [CFG_W-1:0] iap,
    output logic             push,
    output rsp_t             push_data
);

    // stage 5: aligned with the registered bank reads
    logic                     s5_valid_reg;
    smp_ctl_t                 s5_ctl_reg;
    logic [NBANK-1:0][1:0]    bsel;
    logic signed [PIX_W-1:0]  pix_s  [NBANK];
    logic signed [WGT_W:0]    wgt_s  [NBANK];
    logic signed [MUL_W-1:0]  full   [NBANK];
    logic signed [PROD_W-1:0] prod_next [NBANK];

    // stage 6: weighted pixels
    logic                     s6_valid_reg;
    logic                     s6_inr_reg;
    logic signed [PROD_W-1:0] s6_prod_reg [NBANK];
    logic signed [SUM_W-1:0]  sum;
    logic                     pass_next;
    logic [VQ_W-1:0]          vq_next;

    // stage 7: blended value in q1.30
    logic                     s7_valid_reg;
    logic                     s7_inr_reg;
    logic                     s7_pass_reg;
    logic [VQ_W-1:0]          s7_vq_reg;

    // stage 8: scaled value
    logic                     s8_valid_reg;
    logic                     s8_inr_reg;
    logic                     s8_pass_reg;
    logic [SCALED_W-1:0]      s8_scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= smp_valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_valid)
        begin
            s5_ctl_reg <= smp_ctl;
        end
    end

    always_comb
    begin
        bsel[0] = {s5_ctl_reg.rpar[0], s5_ctl_reg.cpar[0]};
        bsel[1] = {s5_ctl_reg.rpar[0], s5_ctl_reg.cpar[1]};
        bsel[2] = {s5_ctl_reg.rpar[1], s5_ctl_reg.cpar[0]};
        bsel[3] = {s5_ctl_reg.rpar[1], s5_ctl_reg.cpar[1]};
        for (int k = 0; k < NBANK; k++)
        begin
            pix_s[k]     = $signed(pix[bsel[k]]);
            wgt_s[k]     = $signed({1'b0, s5_ctl_reg.wgt[k]});
            full[k]      = pix_s[k] * wgt_s[k];
            // weights never exceed 2^32, so the product fits 64 bits
            prod_next[k] = full[k][PROD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_valid_reg)
        begin
            s6_inr_reg  <= s5_ctl_reg.in_range;
            s6_prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        sum = SUM_W'(s6_prod_reg[0]) + SUM_W'(s6_prod_reg[1])
            + SUM_W'(s6_prod_reg[2]) + SUM_W'(s6_prod_reg[3]);
        pass_next = s6_inr_reg && !sum[SUM_W-1];
        vq_next   = sum[VQ_SHIFT +: VQ_W];
    end

    always_ff @(posedge clk)
    begin
        if (s6_valid_reg)
        begin
            s7_inr_reg  <= s6_inr_reg;
            s7_pass_reg <= pass_next;
            s7_vq_reg   <= vq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s7_valid_reg)
        begin
            s8_inr_reg    <= s7_inr_reg;
            s8_pass_reg   <= s7_pass_reg;
            s8_scaled_reg <= s7_vq_reg * iap;
        end
    end

    // a 31-bit value times a 32-bit factor shifted by 24 stays below 2^39,
    // so the 40-bit field never saturates
    assign push                = s8_valid_reg;
    assign push_data.in_range  = s8_inr_reg;
    assign push_data.intensity = s8_pass_reg
                                 ? INT_W'(s8_scaled_reg[SCALED_W-1:SCALE_SHIFT]) : '0;

endmodule

/* rtl/core/bis_rsp_fifo.sv */
// result queue between the blend pipeline and the result channel
module bis_rsp_fifo
    import bis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rsp_t                  push_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp_data,
    output logic [FIFO_CNT_W-1:0] count
);

    rsp_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    assign pop = rsp_valid && rsp_ready;

    // depth is a power of two, pointers wrap on their own
    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign rsp_valid = (count_reg != '0);
    assign rsp_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

/* rtl/core/bilinear_image_sampler.sv */
// top level of the bilinear image sampler
//
// takes one transaction per cycle on req, load or sample alike; a sample
// answers on rsp after the map, bank read and blend stages, a load answers
// nothing. the image lives in four single-read-port rams split by row and
// column parity, so the four neighbours of a point are read together,
// and loads write from the same pipeline stage that issues sample reads, which
// keeps program order without forwarding. results wait in a 16-entry queue;
// req_ready drops while 16 sample results are accepted and not yet taken, so
// the rate is one transaction per cycle whenever rsp keeps up. the image is
// undefined after reset and needs no clearing pass; configuration writes on
// cfg are always taken and belong to an idle block
`include "bilinear_image_sampler_macros.svh"

module bilinear_image_sampler
    import bis_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0]      ppu_reg;
    logic [CFG_W-1:0]      ppu_next;
    logic [CFG_W-1:0]      iap_reg;
    logic [CFG_W-1:0]      iap_next;
    logic [FIFO_CNT_W-1:0] credit_reg;
    logic [FIFO_CNT_W-1:0] credit_next;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  req_fire;
    logic                  smp_fire;
    logic                  rsp_fire;
    mem_port_t             port;
    pix_quad_t             pix;
    logic                  smp_valid;
    smp_ctl_t              smp_ctl;
    logic                  push;
    rsp_t                  push_data;

    assign cfg_ready = 1'b1;
    assign req_ready = (credit_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign req_fire  = req_valid && req_ready;
    assign smp_fire  = req_fire && (req_data.kind == KIND_SAMPLE);
    assign rsp_fire  = rsp_valid && rsp_ready;

    always_comb
    begin
        ppu_next = ppu_reg;
        iap_next = iap_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PIXELS_PER_UNIT:    ppu_next = cfg_data;
                REG_INVERSE_PIXEL_AREA: iap_next = cfg_data;
                default:                ppu_next = ppu_reg;
            endcase
        end
    end

    // one credit per sample result that is in flight or queued
    always_comb
    begin
        case ({smp_fire, rsp_fire})
            2'b10:   credit_next = credit_reg + 1'b1;
            2'b01:   credit_next = credit_reg - 1'b1;
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppu_reg    <= PPU_RESET;
            iap_reg    <= IAP_RESET;
            credit_reg <= '0;
        end
        else
        begin
            ppu_reg    <= ppu_next;
            iap_reg    <= iap_next;
            credit_reg <= credit_next;
        end
    end

    bis_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (req_fire),
        .req       (req_data),
        .ppu       (ppu_reg),
        .port      (port),
        .smp_valid (smp_valid),
        .smp_ctl   (smp_ctl)
    );

    bis_image u_image (
        .clk  (clk),
        .port (port),
        .pix  (pix)
    );

    bis_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ctl   (smp_ctl),
        .pix       (pix),
        .iap       (iap_reg),
        .push      (push),
        .push_data (push_data)
    );

    bis_rsp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .count     (fifo_count)
    );

    `BIS_ASSERT_IMPL(a_credit_bound, 1'b1, credit_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `BIS_ASSERT_IMPL(a_credit_covers_queue, 1'b1, credit_reg >= fifo_count)
    `BIS_ASSERT_NEXT(a_credit_take, smp_fire && !rsp_fire, credit_reg == $past(credit_reg) + 1'b1)
    `BIS_ASSERT_IMPL(a_out_of_range_zero, rsp_valid && !rsp_data.in_range, rsp_data.intensity == '0)

endmodule
